// ===== rtl/stf_pkg.sv =====
`timescale 1ns / 1ps

package stf_pkg;

	// Default buffer size in bytes for each of the two ping-pong halves.
	localparam int unsigned BUFFER_BYTES_DEF = 256;

	// Depth of the command queue between the front and the back.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Stream widths, padded to whole bytes.
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 88;

	// Configuration register indexes.
	localparam logic [1:0] REG_START_CODE  = 2'd0;
	localparam logic [1:0] REG_END_CODE    = 2'd1;
	localparam logic [1:0] REG_ESCAPE_CODE = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [7:0] START_CODE_RST  = 8'h02;
	localparam logic [7:0] END_CODE_RST    = 8'h03;
	localparam logic [7:0] ESCAPE_CODE_RST = 8'h1B;

	// Offset that is added to a special code when it is stuffed.
	localparam logic [7:0] STUFF_OFFSET = 8'h80;

	// Input opcodes.
	localparam logic OP_RX_BYTE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	// Result event kinds.
	localparam logic [2:0] EV_DELIVERED  = 3'd0;
	localparam logic [2:0] EV_REFUSED    = 3'd1;
	localparam logic [2:0] EV_OVERFLOW   = 3'd2;
	localparam logic [2:0] EV_BAD_ESCAPE = 3'd3;
	localparam logic [2:0] EV_READ       = 3'd4;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_READ,
		CMD_EVENT
	} cmd_op_t;

	// One command from the front to the back. The store address travels
	// beside it, since its width follows the buffer size.
	typedef struct packed {
		cmd_op_t    op;
		logic [2:0] kind;
		logic       buf_sel;
		logic [8:0] len;
		logic       in_range;
		logic [7:0] data;
	} cmd_t;

endpackage

// ===== rtl/stf_front.sv =====
`timescale 1ns / 1ps

module stf_front #(
	parameter int unsigned BUFFER_BYTES = stf_pkg::BUFFER_BYTES_DEF,
	parameter int unsigned MAW          = $clog2(2 * BUFFER_BYTES)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           opcode,
	input  logic [7:0]                     rx_byte,
	input  logic                           sink_accepts,
	input  logic                           read_buffer,
	input  logic [7:0]                     read_index,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output stf_pkg::cmd_t                  cmd,
	output logic [MAW-1:0]                 cmd_addr
);
	import stf_pkg::*;

	localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);
	localparam int unsigned CW = (FW > 8) ? FW : 8;

	typedef enum logic [1:0] {
		HUNT,
		RECV,
		ESC
	} mode_t;

	mode_t          mode_q, mode_d;
	logic           active_q, active_d;
	logic [FW-1:0]  fill_q, fill_d;
	logic [7:0]     start_q, end_q, esc_q;

	logic           accept;
	logic           push;
	logic           full;
	logic [7:0]     unstuffed;
	logic           is_code;
	logic [FW-1:0]  frame_len;
	logic [MAW-1:0] wr_addr;
	logic [MAW-1:0] rd_addr;

	assign in_ready  = cmd_ready;
	assign accept    = in_valid && in_ready;
	assign cmd_valid = in_valid && push;

	assign full      = (fill_q == FW'(BUFFER_BYTES));
	assign unstuffed = rx_byte - STUFF_OFFSET;
	assign is_code   = rx_byte[7] &&
		((unstuffed == esc_q) || (unstuffed == start_q) || (unstuffed == end_q));
	assign frame_len = (fill_q >= FW'(2)) ? (fill_q - FW'(2)) : '0;
	assign wr_addr   = MAW'(fill_q) + (active_q ? MAW'(BUFFER_BYTES) : '0);
	assign rd_addr   = MAW'(read_index) + (read_buffer ? MAW'(BUFFER_BYTES) : '0);

	always_comb begin
		mode_d       = mode_q;
		active_d     = active_q;
		fill_d       = fill_q;
		push         = 1'b0;
		cmd.op       = CMD_EVENT;
		cmd.kind     = EV_DELIVERED;
		cmd.buf_sel  = active_q;
		cmd.len      = '0;
		cmd.in_range = 1'b0;
		cmd.data     = rx_byte;
		cmd_addr     = wr_addr;
		if (opcode == OP_READ) begin
			push         = 1'b1;
			cmd.op       = CMD_READ;
			cmd.kind     = EV_READ;
			cmd.buf_sel  = read_buffer;
			cmd.in_range = (CW'(read_index) < CW'(BUFFER_BYTES));
			cmd_addr     = rd_addr;
		end else begin
			case (mode_q)
				RECV: begin
					if (rx_byte == esc_q) begin
						mode_d = ESC;
					end else if (rx_byte == end_q) begin
						push     = 1'b1;
						cmd.kind = sink_accepts ? EV_DELIVERED : EV_REFUSED;
						cmd.len  = 9'(frame_len);
						fill_d   = '0;
						mode_d   = HUNT;
						if (sink_accepts) begin
							active_d = ~active_q;
						end
					end else if (full) begin
						push     = 1'b1;
						cmd.kind = EV_OVERFLOW;
						fill_d   = '0;
						mode_d   = HUNT;
					end else begin
						push   = 1'b1;
						cmd.op = CMD_WRITE;
						fill_d = fill_q + FW'(1);
					end
				end
				ESC: begin
					if (!is_code) begin
						push     = 1'b1;
						cmd.kind = EV_BAD_ESCAPE;
						fill_d   = '0;
						mode_d   = HUNT;
					end else if (full) begin
						push     = 1'b1;
						cmd.kind = EV_OVERFLOW;
						fill_d   = '0;
						mode_d   = HUNT;
					end else begin
						push     = 1'b1;
						cmd.op   = CMD_WRITE;
						cmd.data = unstuffed;
						fill_d   = fill_q + FW'(1);
						mode_d   = RECV;
					end
				end
				default: begin
					mode_d = (rx_byte == start_q) ? RECV : HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= HUNT;
			active_q <= 1'b0;
			fill_q   <= '0;
			start_q  <= START_CODE_RST;
			end_q    <= END_CODE_RST;
			esc_q    <= ESCAPE_CODE_RST;
		end else begin
			if (accept) begin
				mode_q   <= mode_d;
				active_q <= active_d;
				fill_q   <= fill_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_START_CODE:  start_q <= cfg_data;
					REG_END_CODE:    end_q   <= cfg_data;
					REG_ESCAPE_CODE: esc_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== rtl/stf_queue.sv =====
`timescale 1ns / 1ps

module stf_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = stf_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             push, pop;

	assign in_ready  = (count_q != NW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

// ===== rtl/stf_back.sv =====
`timescale 1ns / 1ps

module stf_back #(
	parameter int unsigned BUFFER_BYTES = stf_pkg::BUFFER_BYTES_DEF,
	parameter int unsigned MAW          = $clog2(2 * BUFFER_BYTES)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  stf_pkg::cmd_t                      cmd,
	input  logic [MAW-1:0]                     cmd_addr,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [stf_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic [2:0]                         m_tuser
);
	import stf_pkg::*;

	localparam int unsigned DEPTH = 2 * BUFFER_BYTES;

	logic [7:0]  store_q [DEPTH];

	logic        valid_s1;
	logic [2:0]  kind_s1;
	logic        buf_s1;
	logic [8:0]  len_s1;
	logic        in_range_s1;
	logic [7:0]  rd_s1;
	logic [31:0] dcnt_s1, xcnt_s1;

	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  data_q;
	logic        buf_q;
	logic [8:0]  len_q;
	logic [31:0] dcnt_out_q, xcnt_out_q;

	logic [31:0] dcnt_q, xcnt_q, dcnt_d, xcnt_d;
	logic        adv, pop, is_event;

	assign adv       = valid_s1 && (!out_valid_q || m_tready);
	assign cmd_ready = !valid_s1 || adv;
	assign pop       = cmd_valid && cmd_ready;
	assign is_event  = (cmd.op == CMD_EVENT);

	always_comb begin
		dcnt_d = dcnt_q;
		xcnt_d = xcnt_q;
		if (pop && is_event) begin
			if (cmd.kind == EV_DELIVERED) begin
				dcnt_d = dcnt_q + 32'd1;
			end else begin
				xcnt_d = xcnt_q + 32'd1;
			end
		end
	end

	// Frame store: one write or one registered read per command.
	always_ff @(posedge clk) begin
		if (pop && (cmd.op == CMD_WRITE)) begin
			store_q[cmd_addr] <= cmd.data;
		end
		if (pop) begin
			rd_s1 <= store_q[cmd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1     <= cmd.kind;
			buf_s1      <= cmd.buf_sel;
			len_s1      <= cmd.len;
			in_range_s1 <= (cmd.op == CMD_READ) && cmd.in_range;
			dcnt_s1     <= dcnt_d;
			xcnt_s1     <= xcnt_d;
		end
		if (adv) begin
			kind_q     <= kind_s1;
			data_q     <= in_range_s1 ? rd_s1 : 8'd0;
			buf_q      <= buf_s1;
			len_q      <= len_s1;
			dcnt_out_q <= dcnt_s1;
			xcnt_out_q <= xcnt_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			dcnt_q      <= '0;
			xcnt_q      <= '0;
		end else begin
			dcnt_q <= dcnt_d;
			xcnt_q <= xcnt_d;
			if (pop && (cmd.op != CMD_WRITE)) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {6'd0, xcnt_out_q, dcnt_out_q, len_q, buf_q, data_q};

endmodule

// ===== rtl/stuffed_frame_receiver.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Beat contents
// -------  ---------  ---------------------------------------------------------
// s_axis   in         tuser: opcode; tdata: rx_byte, sink_accepts, read_buffer,
//                     read_index
// m_axis   out        tuser: event_kind; tdata: read_data, frame_buffer,
//                     frame_length, delivered_count, dropped_count
// cfg      in         cfg_we, cfg_index (0 start, 1 end, 2 escape), cfg_data
//
// The block takes one input beat per cycle while the queue has room. The front
// parser decides each byte in the cycle it arrives and queues any command it
// needs; the back end does one frame store access per cycle unless its output
// stalls, and a result is registered in the queue, the read stage and the
// output stage. Reset clears the parser, the counters and the queue; the frame
// store holds whatever it held until bytes are written. A stall at the output
// fills the back end and then the queue, and only then is the input held off.

module stuffed_frame_receiver #(
	parameter int unsigned BUFFER_BYTES = stf_pkg::BUFFER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [7:0]                      cfg_data,
	// Input stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Bits from low: rx_byte[7:0], sink_accepts[8], read_buffer[9],
	// read_index[17:10], zero padding[23:18].
	input  logic [stf_pkg::IN_TDATA_W-1:0]  s_tdata,
	// Bits from low: opcode[0].
	input  logic                            s_tuser,
	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Bits from low: read_data[7:0], frame_buffer[8], frame_length[17:9],
	// delivered_count[49:18], dropped_count[81:50], zero padding[87:82].
	output logic [stf_pkg::OUT_TDATA_W-1:0] m_tdata,
	// Bits from low: event_kind[2:0].
	output logic [2:0]                      m_tuser
);
	import stf_pkg::*;

	localparam int unsigned MAW = $clog2(2 * BUFFER_BYTES);
	localparam int unsigned QW  = $bits(cmd_t) + MAW;

	// Commands leaving the parser and their store address.
	logic           fr_valid, fr_ready;
	cmd_t           fr_cmd;
	logic [MAW-1:0] fr_addr;

	// Commands leaving the queue toward the back end.
	logic           bk_valid, bk_ready;
	cmd_t           bk_cmd;
	logic [MAW-1:0] bk_addr;

	stf_front #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.MAW          (MAW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.opcode       (s_tuser),
		.rx_byte      (s_tdata[7:0]),
		.sink_accepts (s_tdata[8]),
		.read_buffer  (s_tdata[9]),
		.read_index   (s_tdata[17:10]),
		.cmd_valid    (fr_valid),
		.cmd_ready    (fr_ready),
		.cmd          (fr_cmd),
		.cmd_addr     (fr_addr)
	);

	// The queue lets the parser keep taking bytes while the back end is
	// held by a stalled sink.
	stf_queue #(
		.WIDTH     (QW),
		.DEPTH     (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   ({fr_cmd, fr_addr}),
		.out_valid (bk_valid),
		.out_ready (bk_ready),
		.out_data  ({bk_cmd, bk_addr})
	);

	stf_back #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.MAW          (MAW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (bk_valid),
		.cmd_ready    (bk_ready),
		.cmd          (bk_cmd),
		.cmd_addr     (bk_addr),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule

// ===== rtl/stf_checker.sv =====
`timescale 1ns / 1ps

module stf_port_checks (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [stf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [2:0]                      m_tuser
);
	import stf_pkg::*;

	// A result that is offered stays offered until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat withdrawn before it was taken");

	// Only read results carry store data.
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != EV_READ) |-> (m_tdata[7:0] == 8'd0))
		else $error("frame event carries read data");

	// Overflow, bad escape and read results carry no length.
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == EV_OVERFLOW) || (m_tuser == EV_BAD_ESCAPE) ||
		(m_tuser == EV_READ)) |-> (m_tdata[17:9] == 9'd0))
		else $error("length on an event that has none");

	// The padding above the counters is always zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[87:82] == 6'd0))
		else $error("nonzero padding in result beat");

	// Nothing is offered while reset is held.
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result offered during reset");

endmodule

bind stuffed_frame_receiver stf_port_checks u_stf_port_checks (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== test/stf_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams and the register port of the deframer, predicts every
// result beat from the input beats it sees, and compares results in order.
module stf_checker #(
	parameter int unsigned BUFFER_BYTES = stf_pkg::BUFFER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [7:0]                      cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [stf_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [stf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic [2:0]                      m_tuser,
	output int unsigned                     fail_count,
	output int unsigned                     pending_count,
	output int unsigned                     checked_count,
	output int unsigned                     delivered_total,
	output int unsigned                     dropped_total,
	output logic [2*BUFFER_BYTES-1:0]       written_map
);

	import stf_pkg::*;

	typedef enum logic [1:0] {
		RX_HUNT,
		RX_FRAME,
		RX_ESCAPE
	} rx_mode_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data;
		logic        buf_sel;
		logic [8:0]  len;
		logic [31:0] delivered;
		logic [31:0] dropped;
	} frame_event_t;

	logic [7:0]                start_code;
	logic [7:0]                end_code;
	logic [7:0]                escape_code;
	rx_mode_t                  mode;
	logic                      active_half;
	int unsigned               fill;
	logic [7:0]                store [2*BUFFER_BYTES];
	logic [2*BUFFER_BYTES-1:0] written;
	logic [31:0]               delivered;
	logic [31:0]               dropped;
	frame_event_t              expected_events [$];
	int unsigned               errors;
	int unsigned               checked;

	task automatic flag_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		$display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
		errors++;
	endtask

	task automatic post_event(input logic [2:0] kind, input logic [7:0] data,
			input logic half, input int unsigned len);
		frame_event_t ev;
		ev.kind      = kind;
		ev.data      = data;
		ev.buf_sel   = half;
		ev.len       = len[8:0];
		ev.delivered = delivered;
		ev.dropped   = dropped;
		expected_events.push_back(ev);
	endtask

	task automatic drop_frame(input logic [2:0] kind, input int unsigned len);
		dropped++;
		fill = 0;
		mode = RX_HUNT;
		post_event(kind, 8'h00, active_half, len);
	endtask

	// Appends one byte to the active half; fit stays low when the half is full.
	task automatic keep_byte(input logic [7:0] v, output bit fit);
		int unsigned addr;
		fit = 1'b0;
		if (fill < BUFFER_BYTES) begin
			addr = active_half * BUFFER_BYTES + fill;
			store[addr] = v;
			written[addr] = 1'b1;
			fill++;
			fit = 1'b1;
		end
	endtask

	task automatic decode_beat(input logic op, input logic [7:0] rx, input logic acc,
			input logic rhalf, input logic [7:0] ridx);
		int unsigned len;
		logic [7:0]  lit;
		bit          fit;
		if (op == OP_READ) begin
			if (ridx < BUFFER_BYTES) begin
				post_event(EV_READ, store[rhalf * BUFFER_BYTES + ridx], rhalf, 0);
			end else begin
				post_event(EV_READ, 8'h00, rhalf, 0);
			end
		end else begin
			case (mode)
				RX_FRAME: begin
					if (rx == escape_code) begin
						mode = RX_ESCAPE;
					end else if (rx == end_code) begin
						len = (fill >= 2) ? fill - 2 : 0;
						if (acc) begin
							delivered++;
							post_event(EV_DELIVERED, 8'h00, active_half, len);
							active_half = ~active_half;
							fill = 0;
							mode = RX_HUNT;
						end else begin
							drop_frame(EV_REFUSED, len);
						end
					end else begin
						keep_byte(rx, fit);
						if (!fit) drop_frame(EV_OVERFLOW, 0);
					end
				end
				RX_ESCAPE: begin
					lit = rx - STUFF_OFFSET;
					if (rx >= STUFF_OFFSET &&
							(lit == escape_code || lit == start_code || lit == end_code)) begin
						mode = RX_FRAME;
						keep_byte(lit, fit);
						if (!fit) drop_frame(EV_OVERFLOW, 0);
					end else begin
						drop_frame(EV_BAD_ESCAPE, 0);
					end
				end
				default: begin
					mode = (rx == start_code) ? RX_FRAME : RX_HUNT;
				end
			endcase
		end
	endtask

	task automatic check_result(input logic [OUT_TDATA_W-1:0] data, input logic [2:0] kind);
		frame_event_t want;
		if (expected_events.size() == 0) begin
			flag_mismatch("result with nothing pending, event_kind", 0, kind);
		end else begin
			want = expected_events.pop_front();
			checked++;
			if (kind != want.kind) flag_mismatch("event_kind", want.kind, kind);
			if (data[7:0] != want.data) flag_mismatch("read_data", want.data, data[7:0]);
			if (data[8] != want.buf_sel) flag_mismatch("frame_buffer", want.buf_sel, data[8]);
			if (data[17:9] != want.len) flag_mismatch("frame_length", want.len, data[17:9]);
			if (data[49:18] != want.delivered) begin
				flag_mismatch("delivered_count", want.delivered, data[49:18]);
			end
			if (data[81:50] != want.dropped) begin
				flag_mismatch("dropped_count", want.dropped, data[81:50]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code  = START_CODE_RST;
			end_code    = END_CODE_RST;
			escape_code = ESCAPE_CODE_RST;
			mode        = RX_HUNT;
			active_half = 1'b0;
			fill        = 0;
			written     = '0;
			delivered   = '0;
			dropped     = '0;
			errors      = 0;
			checked     = 0;
			expected_events.delete();
			fail_count      <= 0;
			pending_count   <= 0;
			checked_count   <= 0;
			delivered_total <= 0;
			dropped_total   <= 0;
			written_map     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_CODE:  start_code = cfg_data;
					REG_END_CODE:    end_code = cfg_data;
					REG_ESCAPE_CODE: escape_code = cfg_data;
					default: ;
				endcase
			end
			// A result can never belong to a beat taken at the same edge, so
			// results are compared before the new beat is predicted.
			if (m_tvalid && m_tready) check_result(m_tdata, m_tuser);
			if (s_tvalid && s_tready) begin
				decode_beat(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9], s_tdata[17:10]);
			end
			fail_count      <= errors;
			pending_count   <= expected_events.size();
			checked_count   <= checked;
			delivered_total <= delivered;
			dropped_total   <= dropped;
			written_map     <= written;
		end
	end

endmodule

// ===== test/tb_stuffed_frame_receiver.sv =====
`timescale 1ns / 1ps

// Top of the deframer test. This module only makes stimulus and gives the
// verdict; the checker beside the block predicts and compares every result.
module tb_stuffed_frame_receiver;

	import stf_pkg::*;

	localparam int unsigned HALF_BYTES    = BUFFER_BYTES_DEF;
	localparam int unsigned GAP_MAX       = 13;
	// Results trail their beat inside the block; this covers beats that cause
	// no result but may still be inside the block.
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned HOLD_CYCLES   = 120;
	localparam int unsigned TIMEOUT_NS    = 1000000;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [1:0]              cfg_index;
	logic [7:0]              cfg_data;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata;
	logic                    s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic [2:0]              m_tuser;

	int unsigned             fail_count;
	int unsigned             pending_count;
	int unsigned             checked_count;
	int unsigned             delivered_total;
	int unsigned             dropped_total;
	logic [2*HALF_BYTES-1:0] written_map;

	// Codes currently programmed, used to build well-formed frames.
	logic [7:0]  start_c;
	logic [7:0]  end_c;
	logic [7:0]  esc_c;
	// When set, neither side idles between beats.
	bit          no_idle;
	// Asks the result side for one long hold-off.
	bit          hold_req;
	int unsigned beats_sent;
	int unsigned settings_run;

	stuffed_frame_receiver #(
		.BUFFER_BYTES(HALF_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	stf_checker #(
		.BUFFER_BYTES(HALF_BYTES)
	) frame_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.fail_count     (fail_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count),
		.delivered_total(delivered_total),
		.dropped_total  (dropped_total),
		.written_map    (written_map)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offers one input beat after a random gap and returns right after the
	// edge that took it. The valid is lowered only when a gap follows, so a
	// back-to-back beat never sees valid dropped and raised in one step.
	task automatic send_beat(input logic op, input logic [7:0] rx, input logic acc,
			input logic rhalf, input logic [7:0] ridx);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'd0, ridx, rhalf, acc, rx};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// A received byte; the fields that only matter for reads or for the end
	// code carry random values so that their bits toggle anyway.
	task automatic send_byte(input logic [7:0] rx);
		send_beat(OP_RX_BYTE, rx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic send_end(input bit acc);
		send_beat(OP_RX_BYTE, end_c, acc, 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
	endtask

	// Sends one payload byte, stuffing it when it collides with a code. An
	// escape or end code at 0x80 or above cannot be stuffed, so such a byte is
	// replaced. A start code inside a frame is legal as it is, so it is stuffed
	// only at random.
	task automatic send_data(input logic [7:0] v);
		logic [7:0] d;
		d = v;
		while ((d == esc_c || d == end_c) && d >= STUFF_OFFSET) d = 8'($urandom_range(0, 255));
		if (d == esc_c || d == end_c ||
				(d == start_c && d < STUFF_OFFSET && $urandom_range(0, 1) == 1)) begin
			send_byte(esc_c);
			send_byte(d + STUFF_OFFSET);
		end else begin
			send_byte(d);
		end
	endtask

	task automatic send_frame(input int unsigned n, input bit acc);
		send_byte(start_c);
		repeat (n) send_data(8'($urandom_range(0, 255)));
		send_end(acc);
	endtask

	// A frame broken by an escape whose follower is no stuffed code.
	task automatic send_bad_escape_frame();
		logic [7:0] bad;
		bad = 8'($urandom_range(0, 255));
		while (bad >= STUFF_OFFSET && (bad - STUFF_OFFSET == esc_c ||
				bad - STUFF_OFFSET == start_c || bad - STUFF_OFFSET == end_c)) begin
			bad = 8'($urandom_range(0, 255));
		end
		send_byte(start_c);
		repeat ($urandom_range(0, 5)) send_data(8'($urandom_range(0, 255)));
		send_byte(esc_c);
		send_byte(bad);
	endtask

	// Reads a random store entry that has been written at least once; when
	// nothing has been written yet no beat is sent.
	task automatic send_read();
		int unsigned origin;
		int unsigned a;
		int unsigned k;
		bit          found;
		origin = $urandom_range(0, 2*HALF_BYTES - 1);
		found = 1'b0;
		a = origin;
		for (k = 0; k < 2*HALF_BYTES && !found; k++) begin
			a = (origin + k) % (2*HALF_BYTES);
			found = written_map[a];
		end
		if (found) begin
			send_beat(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'(a / HALF_BYTES), 8'(a % HALF_BYTES));
		end
	endtask

	// Bytes outside a frame, mostly steering clear of the start code.
	task automatic send_noise();
		logic [7:0] v;
		repeat ($urandom_range(1, 4)) begin
			v = 8'($urandom_range(0, 255));
			if (v == start_c && $urandom_range(0, 9) != 0) v = v + 8'd1;
			send_byte(v);
		end
	endtask

	// Stops offering beats until every predicted result has come back, then
	// lets the pipeline empty of beats that produce nothing. The leading
	// wait makes sure the checker has seen the final beat.
	task automatic drain();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three code registers on consecutive edges; only called
	// while the block is idle.
	task automatic program_codes(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x);
		start_c = s;
		end_c   = e;
		esc_c   = x;
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_CODE;
		cfg_data  <= s;
		@(posedge clk);
		cfg_index <= REG_END_CODE;
		cfg_data  <= e;
		@(posedge clk);
		cfg_index <= REG_ESCAPE_CODE;
		cfg_data  <= x;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// Mostly well-formed frames of small size with random content, mixed
	// with reads, reads inside frames, broken escapes, unterminated frames
	// and noise. Now and then a whole sequence runs without idling.
	task automatic run_random(input int unsigned target);
		int unsigned first;
		int unsigned pick;
		first = beats_sent;
		while (beats_sent - first < target) begin
			no_idle = ($urandom_range(0, 7) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				send_frame($urandom_range(0, 12), $urandom_range(0, 9) != 0);
			end else if (pick < 55) begin
				send_frame($urandom_range(13, 40), 1'b1);
			end else if (pick < 65) begin
				send_bad_escape_frame();
			end else if (pick < 72) begin
				// Reads in the middle of a frame must leave reception alone.
				send_byte(start_c);
				repeat ($urandom_range(0, 3)) send_data(8'($urandom_range(0, 255)));
				send_read();
				repeat ($urandom_range(1, 3)) send_data(8'($urandom_range(0, 255)));
				send_end($urandom_range(0, 3) != 0);
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 3)) send_read();
			end else if (pick < 95) begin
				send_noise();
			end else begin
				send_byte(start_c);
				repeat ($urandom_range(1, 4)) send_data(8'($urandom_range(0, 255)));
			end
		end
		no_idle = 1'b0;
	endtask

	// Result side: a random stall before each result, a long hold-off when
	// asked, and no stall at all while the sender runs without idling.
	initial begin : result_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid && !hold_req);
		end
	end

	initial begin : stimulus
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_START_CODE;
		cfg_data     = 8'h00;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = OP_RX_BYTE;
		m_tready     = 1'b0;
		no_idle      = 1'b0;
		hold_req     = 1'b0;
		beats_sent   = 0;
		settings_run = 1;
		start_c      = START_CODE_RST;
		end_c        = END_CODE_RST;
		esc_c        = ESCAPE_CODE_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset codes. End and escape codes while
		// hunting are ignored.
		send_byte(end_c);
		send_byte(esc_c);
		// Every code stuffed, a raw start code as data and both byte extremes.
		send_byte(start_c);
		send_byte(esc_c);
		send_byte(start_c + STUFF_OFFSET);
		send_byte(esc_c);
		send_byte(end_c + STUFF_OFFSET);
		send_byte(esc_c);
		send_byte(esc_c + STUFF_OFFSET);
		send_byte(start_c);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_end(1'b1);
		// A one-byte frame: the length, two less than the byte count, clamps at zero.
		send_byte(start_c);
		send_byte(8'hA5);
		send_end(1'b1);
		// An empty frame that the sink refuses.
		send_byte(start_c);
		send_end(1'b0);
		// Bad escapes: a follower below 0x80, and one above that is no code.
		send_byte(start_c);
		send_byte(esc_c);
		send_byte(8'h03);
		send_byte(start_c);
		send_byte(8'h11);
		send_byte(esc_c);
		send_byte(8'hFF);
		// Reads of entries known to be written in each half.
		send_beat(OP_READ, 8'h00, 1'b0, 1'b0, 8'h00);
		send_beat(OP_READ, 8'hFF, 1'b1, 1'b1, 8'h00);

		// A frame that fills its half exactly, then one byte too many for the
		// other half. Afterwards every store entry has been written.
		send_frame(HALF_BYTES, 1'b1);
		send_frame(HALF_BYTES + 1, 1'b1);
		drain();

		// The result side holds off while reads stream in back to back, so
		// the block fills up and must stall its input.
		hold_req = 1'b1;
		no_idle  = 1'b1;
		repeat (12) send_read();
		no_idle = 1'b0;
		run_random(6);
		drain();

		// Extreme code values; an end code of 0xFF cannot be stuffed.
		program_codes(8'h00, 8'hFF, 8'h7F);
		run_random(8);
		drain();

		// Escape equal to end: the escape meaning wins, so no frame closes.
		program_codes(8'hFF, 8'h00, 8'h00);
		run_random(6);
		drain();

		program_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		run_random(8);
		drain();

		program_codes(START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
		run_random(8);
		drain();

		$display("Sent %0d input beats under %0d code settings; %0d results were checked.",
			beats_sent, settings_run, checked_count);
		$display("Frames delivered: %0d, frames dropped: %0d.", delivered_total, dropped_total);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Guards against a hung handshake or results that never arrive.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Run timed out with %0d results outstanding.", pending_count);
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/stf_pkg.sv
rtl/stf_front.sv
rtl/stf_queue.sv
rtl/stf_back.sv
rtl/stuffed_frame_receiver.sv
rtl/stf_checker.sv
test/stf_checker.sv
test/tb_stuffed_frame_receiver.sv
